// ===== rtl/ctmp_pkg.sv =====
// Shared types, constants and the arctangent table for the rectangular-to-polar block.
// No dependencies. Used by every file under rtl.
package ctmp_pkg;

    // Defaults for the top-level parameters
    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int ROTATION_STEPS_DEF = 16;

    // Fraction bits added below the sample LSB during rotation
    localparam int GUARD = 16;

    // Angle accumulator: 2^31 is pi, sum stays within +/-1.6*2^31
    localparam int Z_WIDTH = 34;
    localparam logic signed [Z_WIDTH-1:0] ANGLE_PI = Z_WIDTH'(64'sd2147483648);

    // 1/gain in Q0.32, truncated
    localparam logic [31:0] INV_GAIN_Q32 = 32'h9B74EDA8;

    // Per-item flags that ride along the pipeline
    typedef struct packed {
        logic zero_vec;   // re == 0 and im == 0
        logic im_zero;    // im == 0
        logic re_pos;     // re > 0
    } ctmp_flags_t;

    // atan(2^-i) with 2^31 = pi, rounded to nearest
    function automatic logic [31:0] atan_angle(input logic [4:0] idx);
        logic [31:0] a;
        case (idx)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051E;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2F;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2FA;
            5'd15:   a = 32'h0000517D;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A30;
            5'd19:   a = 32'h00000518;
            5'd20:   a = 32'h0000028C;
            5'd21:   a = 32'h00000146;
            5'd22:   a = 32'h000000A3;
            5'd23:   a = 32'h00000051;
            5'd24:   a = 32'h00000029;
            5'd25:   a = 32'h00000014;
            5'd26:   a = 32'h0000000A;
            5'd27:   a = 32'h00000005;
            5'd28:   a = 32'h00000003;
            5'd29:   a = 32'h00000001;
            5'd30:   a = 32'h00000001;
            5'd31:   a = 32'h00000000;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

// ===== rtl/ctmp_prerot.sv =====
// Input stage: folds the left half-plane onto the right, sets the start angle,
// scales by the guard bits and flags the special axes. Depends on ctmp_pkg.
module ctmp_prerot
    import ctmp_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int XW           = SAMPLE_WIDTH_DEF + GUARD + 3
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] real_part,
    input  logic signed [SAMPLE_WIDTH-1:0] imag_part,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [XW-1:0]           x_out,
    output logic signed [XW-1:0]           y_out,
    output logic signed [Z_WIDTH-1:0]      z_out,
    output ctmp_flags_t                    flags_out
);

    logic                      valid_reg;
    logic signed [XW-1:0]      x_reg, x_next;
    logic signed [XW-1:0]      y_reg, y_next;
    logic signed [Z_WIDTH-1:0] z_reg, z_next;
    ctmp_flags_t               flags_reg, flags_next;
    logic signed [XW-1:0]      re_ext, im_ext;

    assign in_ready = !valid_reg || out_ready;

    // Turn by pi when re < 0, then scale
    always_comb
    begin
        re_ext = {{(XW-SAMPLE_WIDTH){real_part[SAMPLE_WIDTH-1]}}, real_part};
        im_ext = {{(XW-SAMPLE_WIDTH){imag_part[SAMPLE_WIDTH-1]}}, imag_part};
        if (real_part[SAMPLE_WIDTH-1])
        begin
            x_next = (-re_ext) <<< GUARD;
            y_next = (-im_ext) <<< GUARD;
            z_next = imag_part[SAMPLE_WIDTH-1] ? -ANGLE_PI : ANGLE_PI;
        end
        else
        begin
            x_next = re_ext <<< GUARD;
            y_next = im_ext <<< GUARD;
            z_next = '0;
        end
        flags_next.zero_vec = (real_part == '0) && (imag_part == '0);
        flags_next.im_zero  = (imag_part == '0);
        flags_next.re_pos   = !real_part[SAMPLE_WIDTH-1] && (real_part != '0);
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            flags_reg <= flags_next;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign flags_out = flags_reg;

endmodule

// ===== rtl/ctmp_rot_stage.sv =====
// One vectoring micro-rotation with its own register stage.
// Depends on ctmp_pkg for the angle table and flag type.
module ctmp_rot_stage
    import ctmp_pkg::*;
#(
    parameter int XW   = SAMPLE_WIDTH_DEF + GUARD + 3,
    parameter int STEP = 0
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [XW-1:0]      x_in,
    input  logic signed [XW-1:0]      y_in,
    input  logic signed [Z_WIDTH-1:0] z_in,
    input  ctmp_flags_t               flags_in,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [XW-1:0]      x_out,
    output logic signed [XW-1:0]      y_out,
    output logic signed [Z_WIDTH-1:0] z_out,
    output ctmp_flags_t               flags_out
);

    localparam logic [31:0] ANG_U = atan_angle(5'(STEP));
    localparam logic signed [Z_WIDTH-1:0] ANG = $signed({{(Z_WIDTH-32){1'b0}}, ANG_U});

    logic                      valid_reg;
    logic signed [XW-1:0]      x_reg, x_next;
    logic signed [XW-1:0]      y_reg, y_next;
    logic signed [Z_WIDTH-1:0] z_reg, z_next;
    ctmp_flags_t               flags_reg;
    logic signed [XW-1:0]      dx, dy;

    assign in_ready = !valid_reg || out_ready;

    // Rotate toward the x axis; direction from the sign of y
    always_comb
    begin
        dx = y_in >>> STEP;
        dy = x_in >>> STEP;
        if (!y_in[XW-1])
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ANG;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ANG;
        end
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            flags_reg <= flags_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign flags_out = flags_reg;

endmodule

// ===== rtl/ctmp_post.sv =====
// Output back end: gain correction in two multiply stages, phase rounding,
// magnitude rounding and mode select into the output register. Depends on ctmp_pkg.
module ctmp_post
    import ctmp_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int XW           = SAMPLE_WIDTH_DEF + GUARD + 3
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         mode,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [XW-1:0]         x_in,
    input  logic signed [Z_WIDTH-1:0]    z_in,
    input  ctmp_flags_t                  flags_in,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [SAMPLE_WIDTH:0] result_value
);

    localparam int SH = 32 - SAMPLE_WIDTH;
    localparam logic [63:0] MAG_RND = 64'(1) << (GUARD - 1);

    // Stage A: low partial product, phase rounding
    logic                        a_valid_reg;
    logic                        a_ready;
    logic [63:0]                 a_plo_reg;
    logic [31:0]                 a_xhi_reg;
    logic signed [SAMPLE_WIDTH:0] a_ph_reg;
    logic [63:0]                 x64;
    logic signed [Z_WIDTH-1:0]   z_sel;
    logic signed [Z_WIDTH-1:0]   z_rnd;
    logic signed [SAMPLE_WIDTH:0] ph_next;

    // Stage B: high partial product
    logic                        b_valid_reg;
    logic                        b_ready;
    logic [63:0]                 b_phi_reg;
    logic [31:0]                 b_carry_reg;
    logic signed [SAMPLE_WIDTH:0] b_ph_reg;

    // Stage C: output register
    logic                        c_valid_reg;
    logic signed [SAMPLE_WIDTH:0] c_result_reg, c_result_next;
    logic [63:0]                 mag_sum;

    assign in_ready = !a_valid_reg || a_ready;
    assign a_ready  = !b_valid_reg || b_ready;
    assign b_ready  = !c_valid_reg || out_ready;

    // x is never negative after vectoring
    assign x64 = {{(64-XW){1'b0}}, x_in};

    // Axis and origin overrides for the angle
    always_comb
    begin
        if (flags_in.zero_vec)
            z_sel = '0;
        else if (flags_in.im_zero)
            z_sel = flags_in.re_pos ? '0 : ANGLE_PI;
        else
            z_sel = z_in;
    end

    // Round half up to SAMPLE_WIDTH bits of angle
    generate
        if (SH > 0)
        begin : g_ph_round
            localparam logic signed [Z_WIDTH-1:0] PH_RND = Z_WIDTH'(1) <<< (SH - 1);
            assign z_rnd = (z_sel + PH_RND) >>> SH;
        end
        else
        begin : g_ph_full
            assign z_rnd = z_sel;
        end
    endgenerate

    // Wrap to a signed SAMPLE_WIDTH value
    assign ph_next = {z_rnd[SAMPLE_WIDTH-1], z_rnd[SAMPLE_WIDTH-1:0]};

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                a_valid_reg <= in_valid;
            if (a_ready)
                b_valid_reg <= a_valid_reg;
            if (b_ready)
                c_valid_reg <= b_valid_reg;
        end
    end

    // Stage A payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            a_plo_reg <= {32'b0, x64[31:0]} * {32'b0, INV_GAIN_Q32};
            a_xhi_reg <= x64[63:32];
            a_ph_reg  <= ph_next;
        end
    end

    // Stage B payload
    always_ff @(posedge clk)
    begin
        if (a_valid_reg && a_ready)
        begin
            b_phi_reg   <= {32'b0, a_xhi_reg} * {32'b0, INV_GAIN_Q32};
            b_carry_reg <= a_plo_reg[63:32];
            b_ph_reg    <= a_ph_reg;
        end
    end

    // Stage C: sum, round and select
    always_comb
    begin
        mag_sum = b_phi_reg + {32'b0, b_carry_reg} + MAG_RND;
        if (mode)
            c_result_next = b_ph_reg;
        else
            c_result_next = $signed(mag_sum[GUARD+SAMPLE_WIDTH:GUARD]);
    end

    always_ff @(posedge clk)
    begin
        if (b_valid_reg && b_ready)
            c_result_reg <= c_result_next;
    end

    assign out_valid    = c_valid_reg;
    assign result_value = c_result_reg;

endmodule

// ===== rtl/complex_to_magnitude_or_phase.sv =====
// Rectangular-to-polar converter: magnitude or phase of a complex sample per item.
// Stages: one input stage, one register stage per rotation, two multiply stages and the output register.
// Throughput: one item per cycle; every stage holds its item under back-pressure.
// Reset (rst_n low, asynchronous) clears all valid bits and sets output_mode to magnitude.
// Depends on ctmp_pkg, ctmp_prerot, ctmp_rot_stage and ctmp_post.
module complex_to_magnitude_or_phase
    import ctmp_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
    parameter int ROTATION_STEPS = ROTATION_STEPS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         output_mode,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] real_part,
    input  logic signed [SAMPLE_WIDTH-1:0] imag_part,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [SAMPLE_WIDTH:0] result_value
);

    // Rotation datapath width: sample, guard bits and CORDIC growth
    localparam int XW = SAMPLE_WIDTH + GUARD + 3;

    logic output_mode_reg;

    logic                      pv    [0:ROTATION_STEPS];
    logic                      pr    [0:ROTATION_STEPS];
    logic signed [XW-1:0]      px    [0:ROTATION_STEPS];
    logic signed [XW-1:0]      py    [0:ROTATION_STEPS];
    logic signed [Z_WIDTH-1:0] pz    [0:ROTATION_STEPS];
    ctmp_flags_t               pflags[0:ROTATION_STEPS];

    // Mode register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            output_mode_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            output_mode_reg <= output_mode;
    end

    // Input stage
    ctmp_prerot #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .XW           (XW)
    ) u_prerot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .real_part (real_part),
        .imag_part (imag_part),
        .out_valid (pv[0]),
        .out_ready (pr[0]),
        .x_out     (px[0]),
        .y_out     (py[0]),
        .z_out     (pz[0]),
        .flags_out (pflags[0])
    );

    // Rotation stages
    generate
        for (genvar i = 0; i < ROTATION_STEPS; i++)
        begin : g_rot
            ctmp_rot_stage #(
                .XW   (XW),
                .STEP (i)
            ) u_rot (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (pv[i]),
                .in_ready  (pr[i]),
                .x_in      (px[i]),
                .y_in      (py[i]),
                .z_in      (pz[i]),
                .flags_in  (pflags[i]),
                .out_valid (pv[i+1]),
                .out_ready (pr[i+1]),
                .x_out     (px[i+1]),
                .y_out     (py[i+1]),
                .z_out     (pz[i+1]),
                .flags_out (pflags[i+1])
            );
        end
    endgenerate

    // Gain correction, rounding and output register
    ctmp_post #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .XW           (XW)
    ) u_post (
        .clk          (clk),
        .rst_n        (rst_n),
        .mode         (output_mode_reg),
        .in_valid     (pv[ROTATION_STEPS]),
        .in_ready     (pr[ROTATION_STEPS]),
        .x_in         (px[ROTATION_STEPS]),
        .z_in         (pz[ROTATION_STEPS]),
        .flags_in     (pflags[ROTATION_STEPS]),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value)
    );

    // A free output side leaves the whole pipeline able to take an item
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output side is ready");

    // Magnitude never sets the top bit
    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !output_mode_reg) |-> !result_value[SAMPLE_WIDTH])
        else $error("magnitude out of range");

    // Phase is a sign-extended SAMPLE_WIDTH value
    a_phase_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && output_mode_reg)
            |-> (result_value[SAMPLE_WIDTH] == result_value[SAMPLE_WIDTH-1]))
        else $error("phase not wrapped to sample width");

endmodule
